/* rtl/core/mds_pkg.sv */
package mds_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int Q_W     = 48;
  localparam int DIV_STEPS = Q_W + 1;

  localparam logic [Q_W-1:0] QMAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] QMIN = {1'b1, {(Q_W-1){1'b0}}};
  localparam logic [Q_W:0]   QONE = (Q_W+1)'(1) << 24;

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_RES   = 3'd1;
  localparam logic [2:0] FUNC_ISRC  = 3'd2;
  localparam logic [2:0] FUNC_VSRC  = 3'd3;
  localparam logic [2:0] FUNC_IND   = 3'd4;
  localparam logic [2:0] FUNC_RDMAT = 3'd5;
  localparam logic [2:0] FUNC_RDVEC = 3'd6;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_NODE  = 2'd1;
  localparam logic [1:0] ERR_INDEX = 2'd2;
  localparam logic [1:0] ERR_RES   = 2'd3;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_VSRC_COUNT = 1'b1;

  localparam logic [2:0] NUM_OPS = 3'd5;

  typedef struct packed {
    logic       load;
    logic       clr_step;
    logic       div_step;
    logic       op_rd;
    logic       op_wr;
    logic       item_rd;
    logic       out_load;
    logic [2:0] op_idx;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       err_any;
    logic       clr_last;
    logic       div_last;
    logic       op_en;
  } sts_t;

endpackage

/* rtl/core/mds_ctrl.sv */
module mds_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  mds_pkg::sts_t sts,
  output mds_pkg::cmd_t cmd
);
  import mds_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_OPS  = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_WR   = 4'd6;
  localparam logic [3:0] S_IRD  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state, state_next;
  logic [2:0] op_idx, op_idx_next;
  logic       clr_item, clr_item_next;

  always_comb begin
    state_next    = state;
    op_idx_next   = op_idx;
    clr_item_next = clr_item;
    cmd           = '0;
    cmd.op_idx    = op_idx;
    s_tready      = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        op_idx_next = '0;
        if (sts.err_any) begin
          state_next = S_DONE;
        end else begin
          case (sts.func)
            FUNC_CLEAR: begin
              clr_item_next = 1'b1;
              state_next    = S_CLR;
            end
            FUNC_RES: state_next = S_DIV;
            FUNC_ISRC, FUNC_VSRC, FUNC_IND: state_next = S_OPS;
            FUNC_RDMAT, FUNC_RDVEC: state_next = S_IRD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          clr_item_next = 1'b0;
          state_next    = clr_item ? S_DONE : S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_OPS;
      end
      S_OPS: begin
        if (op_idx == NUM_OPS) begin
          state_next = S_DONE;
        end else if (sts.op_en) begin
          state_next = S_RD;
        end else begin
          op_idx_next = op_idx + 3'd1;
        end
      end
      S_RD: begin
        cmd.op_rd  = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.op_wr   = 1'b1;
        op_idx_next = op_idx + 3'd1;
        state_next  = S_OPS;
      end
      S_IRD: begin
        cmd.item_rd = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      op_idx   <= '0;
      clr_item <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      op_idx   <= op_idx_next;
      clr_item <= clr_item_next;
      if (cmd.out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready outside idle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> $past(state) == S_RD) else $error("write without read");
  a_op_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WR) |-> op_idx < NUM_OPS) else $error("op index");

endmodule

/* rtl/core/mds_datapath.sv */
module mds_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic [87:0]   s_tdata,
  output logic [55:0]   m_tdata,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  mds_pkg::cmd_t cmd,
  output mds_pkg::sts_t sts
);
  import mds_pkg::*;

  logic [6:0] node_count;
  logic [5:0] vsrc_count;

  logic [2:0]       func;
  logic [5:0]       na, nb, rr, rc;
  logic [DIM_W-1:0] brow;
  logic [Q_W-1:0]   val;
  logic [1:0]       err;

  logic [2:0]       in_func;
  logic [5:0]       in_a, in_b, in_br, in_rr, in_rc;
  logic [Q_W-1:0]   in_val;
  logic [6:0]       base;
  logic [7:0]       row_v, row_l;
  logic [1:0]       in_err;
  logic             a_ok, b_ok;

  assign in_func = s_tdata[2:0];
  assign in_a    = s_tdata[8:3];
  assign in_b    = s_tdata[14:9];
  assign in_br   = s_tdata[20:15];
  assign in_val  = s_tdata[68:21];
  assign in_rr   = s_tdata[74:69];
  assign in_rc   = s_tdata[80:75];

  assign base  = (node_count == 7'd0) ? 7'd0 : node_count - 7'd1;
  assign row_v = {1'b0, base} + {2'b00, in_br};
  assign row_l = {1'b0, base} + {2'b00, vsrc_count} + {2'b00, in_br};
  assign a_ok  = (in_a == 6'd0) || ({1'b0, in_a} < node_count);
  assign b_ok  = (in_b == 6'd0) || ({1'b0, in_b} < node_count);

  always_comb begin
    in_err = ERR_OK;
    if (in_func inside {FUNC_RES, FUNC_ISRC, FUNC_VSRC, FUNC_IND}) begin
      if (!a_ok || !b_ok) begin
        in_err = ERR_NODE;
      end else begin
        case (in_func)
          FUNC_RES:  if ($signed(in_val) <= 0) in_err = ERR_RES;
          FUNC_VSRC: if (in_br >= vsrc_count || row_v >= 8'(MAX_DIM)) in_err = ERR_INDEX;
          FUNC_IND:  if (row_l >= 8'(MAX_DIM)) in_err = ERR_INDEX;
          default:   in_err = ERR_OK;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd1;
      vsrc_count <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data;
        CFG_VSRC_COUNT: vsrc_count <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func <= in_func;
      na   <= in_a;
      nb   <= in_b;
      rr   <= in_rr;
      rc   <= in_rc;
      val  <= in_val;
      err  <= in_err;
      brow <= (in_func == FUNC_VSRC) ? row_v[DIM_W-1:0] : row_l[DIM_W-1:0];
    end
  end

  logic [ADDR_W-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst || cmd.load) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + ADDR_W'(1);
  end

  logic [5:0]   div_cnt;
  logic [Q_W:0] rem, quo, div_t;
  logic         div_ge;
  assign div_t  = {rem[Q_W-1:0], (div_cnt == 6'd0)};
  assign div_ge = div_t >= {1'b0, val};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_cnt <= '0;
      rem     <= '0;
      quo     <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 6'd1;
      rem     <= div_ge ? div_t - {1'b0, val} : div_t;
      quo     <= {quo[Q_W-1:0], div_ge};
    end
  end

  logic           recip_sat;
  logic [Q_W-1:0] g;
  assign recip_sat = (func == FUNC_RES) && (quo[Q_W] || quo[Q_W-1]);
  assign g         = recip_sat ? QMAX : quo[Q_W-1:0];

  logic [DIM_W-1:0] am1, bm1, op_row, op_col;
  logic [Q_W:0]     op_delta, gx, vx;
  logic             op_vec, op_set, op_en;
  assign am1 = na - 6'd1;
  assign bm1 = nb - 6'd1;
  assign gx  = {1'b0, g};
  assign vx  = {val[Q_W-1], val};

  always_comb begin
    op_row   = am1;
    op_col   = am1;
    op_delta = '0;
    op_vec   = 1'b0;
    op_set   = 1'b0;
    op_en    = 1'b0;
    case (func)
      FUNC_RES: begin
        case (cmd.op_idx)
          3'd0: begin op_row = am1; op_col = bm1; op_delta = -gx;
            op_en = (na != 6'd0) && (nb != 6'd0); end
          3'd1: begin op_row = bm1; op_col = am1; op_delta = -gx;
            op_en = (na != 6'd0) && (nb != 6'd0); end
          3'd2: begin op_row = am1; op_col = am1; op_delta = gx; op_en = na != 6'd0; end
          3'd3: begin op_row = bm1; op_col = bm1; op_delta = gx; op_en = nb != 6'd0; end
          default: op_en = 1'b0;
        endcase
      end
      FUNC_ISRC: begin
        op_vec = 1'b1;
        case (cmd.op_idx)
          3'd0: begin op_row = am1; op_delta = -vx; op_en = na != 6'd0; end
          3'd1: begin op_row = bm1; op_delta = vx; op_en = nb != 6'd0; end
          default: op_en = 1'b0;
        endcase
      end
      FUNC_VSRC, FUNC_IND: begin
        case (cmd.op_idx)
          3'd0: begin op_vec = 1'b1; op_set = 1'b1; op_row = brow; op_en = 1'b1;
            op_delta = (func == FUNC_VSRC) ? vx : '0; end
          3'd1: begin op_row = brow; op_col = am1; op_delta = QONE; op_en = na != 6'd0; end
          3'd2: begin op_row = am1; op_col = brow; op_delta = QONE; op_en = na != 6'd0; end
          3'd3: begin op_row = brow; op_col = bm1; op_delta = -QONE; op_en = nb != 6'd0; end
          3'd4: begin op_row = bm1; op_col = brow; op_delta = -QONE; op_en = nb != 6'd0; end
          default: op_en = 1'b0;
        endcase
      end
      default: op_en = 1'b0;
    endcase
  end

  logic [Q_W-1:0] mat [MAX_DIM*MAX_DIM];
  logic [Q_W-1:0] vec [MAX_DIM];
  logic [Q_W-1:0] mat_q, vec_q, cur, wdata;
  logic [Q_W+1:0] sum;
  logic           sum_hi, sum_lo, sat_acc;

  assign cur    = op_vec ? vec_q : mat_q;
  assign sum    = {{2{cur[Q_W-1]}}, cur} + {op_delta[Q_W], op_delta};
  assign sum_hi = $signed(sum) > $signed({2'b00, QMAX});
  assign sum_lo = $signed(sum) < $signed({2'b11, QMIN});
  always_comb begin
    if (op_set) wdata = op_delta[Q_W-1:0];
    else if (sum_hi) wdata = QMAX;
    else if (sum_lo) wdata = QMIN;
    else wdata = sum[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mat[clr_cnt] <= '0;
      vec[clr_cnt[DIM_W-1:0]] <= '0;
    end else if (cmd.op_wr) begin
      if (op_vec) vec[op_row] <= wdata;
      else mat[{op_row, op_col}] <= wdata;
    end
    if (cmd.item_rd) begin
      mat_q <= mat[{rr, rc}];
      vec_q <= vec[rr];
    end else if (cmd.op_rd) begin
      mat_q <= mat[{op_row, op_col}];
      vec_q <= vec[op_row];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) sat_acc <= 1'b0;
    else if (cmd.op_wr && !op_set && (sum_hi || sum_lo)) sat_acc <= 1'b1;
  end

  logic [Q_W-1:0] rd_out;
  logic [1:0]     err_out;
  logic           sat_out;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      err_out <= err;
      sat_out <= (err == ERR_OK) && (sat_acc || recip_sat);
      if (err != ERR_OK) rd_out <= '0;
      else if (func == FUNC_RDMAT) rd_out <= mat_q;
      else if (func == FUNC_RDVEC) rd_out <= vec_q;
      else rd_out <= '0;
    end
  end

  assign m_tdata = {5'd0, sat_out, err_out, rd_out};

  assign sts.func     = func;
  assign sts.err_any  = err != ERR_OK;
  assign sts.clr_last = clr_cnt == {ADDR_W{1'b1}};
  assign sts.div_last = div_cnt == 6'(DIV_STEPS - 1);
  assign sts.op_en    = op_en;

endmodule

/* rtl/core/mna_dc_stamp_engine.sv */
// Reset: a clearing pass over the store; no request is taken meanwhile.
// Resistor: a 49-step reciprocal divider, then up to four read-modify-writes.
// Current source: up to two read-modify-writes; voltage source or inductor: up to five.
// Read: a single store access; clear: one matrix entry per cycle.
// One item at a time; a new request is taken while the previous result waits.
module mna_dc_stamp_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,  // func, node_a, node_b, branch_number, element_value, read_row, read_col
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // read_data, error_code, saturated
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import mds_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mds_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* tb/mna_dc_stamp_engine_check.sv */
`timescale 1ns / 1ps

module mna_dc_stamp_engine_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [87:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output int          pending,
  output int          errors
);
  import mds_pkg::*;

  typedef struct {
    logic [47:0] data;
    logic [1:0]  err;
    logic        sat;
  } stamp_result_t;

  localparam longint QMAX_L = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMIN_L = -QMAX_L - 1;
  localparam longint QONE_L = 64'sd1 << 24;

  longint        sys_mat [0:MAX_DIM*MAX_DIM-1];
  longint        rhs_vec [0:MAX_DIM-1];
  int unsigned   node_cnt;
  int unsigned   vsrc_cnt;
  logic          sat_seen;
  stamp_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic longint clamp_q(longint v);
    if (v > QMAX_L) begin
      sat_seen = 1'b1;
      return QMAX_L;
    end
    if (v < QMIN_L) begin
      sat_seen = 1'b1;
      return QMIN_L;
    end
    return v;
  endfunction

  task automatic mat_add(int unsigned r, int unsigned c, longint d);
    int unsigned idx;
    idx = (r % MAX_DIM) * MAX_DIM + (c % MAX_DIM);
    sys_mat[idx] = clamp_q(sys_mat[idx] + d);
  endtask

  task automatic vec_add(int unsigned r, longint d);
    rhs_vec[r % MAX_DIM] = clamp_q(rhs_vec[r % MAX_DIM] + d);
  endtask

  task automatic stamp_branch(int unsigned row, int unsigned a, int unsigned b, longint src);
    rhs_vec[row] = src;
    if (a > 0) begin
      mat_add(row, a - 1, QONE_L);
      mat_add(a - 1, row, QONE_L);
    end
    if (b > 0) begin
      mat_add(row, b - 1, -QONE_L);
      mat_add(b - 1, row, -QONE_L);
    end
  endtask

  task automatic clear_store();
    foreach (sys_mat[i]) sys_mat[i] = 0;
    foreach (rhs_vec[i]) rhs_vec[i] = 0;
  endtask

  task automatic predict_stamp(logic [87:0] req);
    logic [2:0]    func;
    int unsigned   a, b, br, rr, rc, base, row;
    longint        val, g, data;
    longint unsigned q;
    logic [1:0]    err;
    stamp_result_t res;
    func = req[2:0];
    a    = 32'(req[8:3]);
    b    = 32'(req[14:9]);
    br   = 32'(req[20:15]);
    val  = {{16{req[68]}}, req[68:21]};
    rr   = 32'(req[74:69]);
    rc   = 32'(req[80:75]);
    base = (node_cnt == 0) ? 0 : node_cnt - 1;
    data = 0;
    err  = ERR_OK;
    sat_seen = 1'b0;
    if (func >= FUNC_RES && func <= FUNC_IND) begin
      if ((a != 0 && a >= node_cnt) || (b != 0 && b >= node_cnt)) err = ERR_NODE;
      else if ((a != 0 && a - 1 >= MAX_DIM) || (b != 0 && b - 1 >= MAX_DIM)) err = ERR_INDEX;
    end
    case (func)
      FUNC_CLEAR: clear_store();
      FUNC_RES: begin
        if (err == ERR_OK && val <= 0) err = ERR_RES;
        if (err == ERR_OK) begin
          q = (64'd1 << 48) / longint'(val);
          if (q > longint'(QMAX_L)) begin
            g = QMAX_L;
            sat_seen = 1'b1;
          end else begin
            g = longint'(q);
          end
          if (a > 0 && b > 0) begin
            mat_add(a - 1, b - 1, -g);
            mat_add(b - 1, a - 1, -g);
          end
          if (a > 0) mat_add(a - 1, a - 1, g);
          if (b > 0) mat_add(b - 1, b - 1, g);
        end
      end
      FUNC_ISRC: begin
        if (err == ERR_OK) begin
          if (a > 0) vec_add(a - 1, -val);
          if (b > 0) vec_add(b - 1, val);
        end
      end
      FUNC_VSRC: begin
        row = base + br;
        if (err == ERR_OK && (br >= vsrc_cnt || row >= MAX_DIM)) err = ERR_INDEX;
        if (err == ERR_OK) stamp_branch(row, a, b, val);
      end
      FUNC_IND: begin
        row = base + vsrc_cnt + br;
        if (err == ERR_OK && row >= MAX_DIM) err = ERR_INDEX;
        if (err == ERR_OK) stamp_branch(row, a, b, 0);
      end
      FUNC_RDMAT: begin
        if (rr >= MAX_DIM || rc >= MAX_DIM) err = ERR_INDEX;
        else data = sys_mat[rr * MAX_DIM + rc];
      end
      FUNC_RDVEC: begin
        if (rr >= MAX_DIM) err = ERR_INDEX;
        else data = rhs_vec[rr];
      end
      default: ;
    endcase
    if (err != ERR_OK) sat_seen = 1'b0;
    res.data = data[47:0];
    res.err  = err;
    res.sat  = sat_seen;
    expected_results.push_back(res);
  endtask

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
    node_cnt = 1;
    vsrc_cnt = 0;
    clear_store();
  end

  always @(posedge clk) begin
    stamp_result_t want;
    if (rst) begin
      node_cnt = 1;
      vsrc_cnt = 0;
      clear_store();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_cnt = 32'(cfg_data);
        else vsrc_cnt = 32'(cfg_data[5:0]);
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", m_tdata[47:0], '0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[47:0] !== want.data) report("read_data", m_tdata[47:0], want.data);
          if (m_tdata[49:48] !== want.err)
            report("error_code", 48'(m_tdata[49:48]), 48'(want.err));
          if (m_tdata[50] !== want.sat)
            report("saturated", 48'(m_tdata[50]), 48'(want.sat));
        end
      end
      if (s_tvalid && s_tready) predict_stamp(s_tdata);
    end
  end

endmodule

/* tb/mna_dc_stamp_engine_test.sv */
`timescale 1ns / 1ps

module mna_dc_stamp_engine_test;
  import mds_pkg::*;

  localparam int WATCHDOG_LIMIT = 30000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic        cfg_we;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  int          pending;
  int          errors;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;
  int          quiet_cycles;
  int unsigned cur_nodes;
  int unsigned cur_vsrcs;

  mna_dc_stamp_engine dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mna_dc_stamp_engine_check checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles--;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] func, int unsigned a, int unsigned b,
                              int unsigned br, logic [47:0] val,
                              int unsigned rr, int unsigned rc);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, rc[5:0], rr[5:0], val, br[5:0], b[5:0], a[5:0], func};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic set_config(int unsigned nodes, int unsigned vsrcs);
    drain();
    cfg_we    = 1'b1;
    cfg_index = CFG_NODE_COUNT;
    cfg_data  = nodes[6:0];
    @(negedge clk);
    cfg_index = CFG_VSRC_COUNT;
    cfg_data  = vsrcs[6:0];
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_nodes = nodes;
    cur_vsrcs = vsrcs;
  endtask

  function automatic int unsigned pick_node();
    if ($urandom_range(0, 99) < 8 || cur_nodes < 2) return $urandom_range(0, 63);
    return $urandom_range(0, cur_nodes - 1);
  endfunction

  function automatic logic [47:0] pick_value(logic [2:0] func);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (func == FUNC_RES) begin
      if (sel < 5) return -48'($urandom_range(0, 3));
      if (sel < 20) return 48'($urandom_range(1, 1000));
      if (sel < 60) return 48'($urandom_range(1, 64)) << 22;
      return {1'b0, 15'($urandom), 32'($urandom)};
    end
    if (sel < 50) return 48'($urandom_range(0, 200)) << 20;
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic send_random();
    int unsigned sel;
    int unsigned span;
    logic [2:0]  func;
    sel = $urandom_range(0, 199);
    if (sel < 1) func = FUNC_CLEAR;
    else if (sel < 4) func = 3'd7;
    else if (sel < 60) func = FUNC_RES;
    else if (sel < 80) func = FUNC_ISRC;
    else if (sel < 100) func = FUNC_VSRC;
    else if (sel < 115) func = FUNC_IND;
    else if (sel < 165) func = FUNC_RDMAT;
    else func = FUNC_RDVEC;
    span = cur_nodes + 2 * cur_vsrcs + 4;
    if (span > 63 || $urandom_range(0, 9) == 0) span = 63;
    send_request(func, pick_node(), pick_node(),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(0, cur_vsrcs + 1),
                 pick_value(func), $urandom_range(0, span), $urandom_range(0, span));
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_NODE_COUNT;
    cfg_data = '0;
    hold_cycles = 0;
    quiet_cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 71;
    cur_nodes = 1;
    cur_vsrcs = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    send_request(FUNC_RES, 1, 0, 0, 48'd1 << 24, 0, 0);
    set_config(5, 2);
    send_request(FUNC_RES, 1, 2, 0, 48'd1 << 24, 0, 0);
    send_request(FUNC_RES, 3, 0, 0, 48'd1, 0, 0);
    send_request(FUNC_RES, 2, 3, 0, 48'd0, 0, 0);
    send_request(FUNC_RES, 2, 3, 0, 48'h8000_0000_0000, 0, 0);
    send_request(FUNC_RES, 7, 1, 0, 48'd5, 0, 0);
    send_request(FUNC_RES, 3, 3, 0, 48'd3, 0, 0);
    send_request(FUNC_ISRC, 1, 2, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
    send_request(FUNC_ISRC, 1, 2, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
    send_request(FUNC_VSRC, 1, 2, 0, 48'hFFFF_FF00_0000, 0, 0);
    send_request(FUNC_VSRC, 1, 2, 2, 48'd7, 0, 0);
    send_request(FUNC_IND, 3, 4, 0, 48'd9, 0, 0);
    send_request(FUNC_RDMAT, 0, 0, 0, 0, 0, 1);
    send_request(FUNC_RDMAT, 0, 0, 0, 0, 4, 0);
    send_request(FUNC_RDVEC, 0, 0, 0, 0, 0, 0);
    send_request(FUNC_RDVEC, 0, 0, 0, 0, 4, 0);
    send_request(3'd7, 63, 63, 63, '1, 63, 63);
    send_request(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
    send_request(FUNC_RDMAT, 0, 0, 0, 0, 0, 0);
    set_config(64, 63);
    send_request(FUNC_VSRC, 63, 0, 0, 48'd1, 0, 0);
    send_request(FUNC_VSRC, 63, 0, 1, 48'd1, 0, 0);
    send_request(FUNC_IND, 1, 63, 0, 48'd1, 0, 0);
    send_request(FUNC_RES, 63, 62, 0, 48'h7FFF_FFFF_FFFF, 0, 0);
    send_request(FUNC_RDMAT, 0, 0, 0, 0, 63, 63);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 71 : 0;
      recv_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 16 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        case (chunk)
          0: set_config(1, 0);
          1: set_config(64, 63);
          default: set_config($urandom_range(2, 24), $urandom_range(0, 12));
        endcase
        if (phase == 2 && chunk == 3) begin
          hold_cycles = 400;
        end
        repeat (100) send_random();
      end
    end

    drain();
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
